// ----- rtl/core/segi_pkg.sv -----
package segi_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 16;

  // Difference, product and sum widths of the integer geometry.
  localparam int DW  = COORD_BITS + 1;
  localparam int PW  = 2 * DW;
  localparam int SW  = PW + 1;
  // Magnitude of the denominator and of a normalised numerator.
  localparam int MW  = PW;
  // Quotient, scaled product and dividend widths.
  localparam int QW  = COORD_BITS + FRAC_BITS;
  localparam int PRW = MW + COORD_BITS;
  localparam int NW  = PRW + FRAC_BITS;
  // Output word and working width of the final add and clamp.
  localparam int OUT_W = 32;
  localparam int OW    = COORD_BITS + FRAC_BITS + 2;
  localparam int EW    = (OW > OUT_W + 1) ? OW : OUT_W + 1;

  localparam logic [1:0] KIND_NONE    = 2'd0;
  localparam logic [1:0] KIND_SHARED  = 2'd1;
  localparam logic [1:0] KIND_POINT   = 2'd2;
  localparam logic [1:0] KIND_OVERLAP = 2'd3;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] by_coord;
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
    logic signed [COORD_BITS-1:0] dx;
    logic signed [COORD_BITS-1:0] dy;
  } seg_in_t;

  typedef struct packed {
    logic                    hit;
    logic [1:0]              kind;
    logic signed [OUT_W-1:0] px;
    logic signed [OUT_W-1:0] py;
  } seg_out_t;

  // Decision that rides alongside the divider.
  typedef struct packed {
    logic                         hit;
    logic [1:0]                   kind;
    logic                         pt;
    logic                         off;
    logic                         negx;
    logic                         negy;
    logic signed [COORD_BITS-1:0] basex;
    logic signed [COORD_BITS-1:0] basey;
  } segi_side_t;

endpackage

// ----- rtl/core/segi_front.sv -----
module segi_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  segi_pkg::seg_in_t    seg,
  output logic                 out_valid,
  output segi_pkg::segi_side_t side,
  output logic [segi_pkg::NW-1:0] n_x,
  output logic [segi_pkg::NW-1:0] n_y,
  output logic [segi_pkg::MW-1:0] den
);
  import segi_pkg::*;

  logic [5:1] vld;

  // stage 1: differences and endpoint equality
  logic signed [DW-1:0] s1_rx, s1_ry, s1_sx, s1_sy, s1_wx, s1_wy, s1_ux, s1_uy;
  logic                 s1_shared;
  logic signed [COORD_BITS-1:0] s1_ax, s1_ay, s1_cx, s1_cy;

  // stage 2: products
  logic signed [PW-1:0] s2_ws1, s2_ws2, s2_rs1, s2_rs2, s2_wr1, s2_wr2;
  logic signed [PW-1:0] s2_wrx, s2_wry, s2_urx, s2_ury, s2_rrx, s2_rry;
  logic signed [PW-1:0] s2_wsx, s2_wsy, s2_ssx, s2_ssy;
  logic                 s2_shared, s2_rz, s2_sz, s2_negx, s2_negy;
  logic [COORD_BITS-1:0] s2_absx, s2_absy;
  logic signed [COORD_BITS-1:0] s2_ax, s2_ay, s2_cx, s2_cy;

  // stage 3: cross and dot products
  logic signed [SW-1:0] s3_d, s3_tn, s3_un, s3_t0, s3_t1, s3_rr, s3_dws, s3_ss;
  logic                 s3_shared, s3_rz, s3_sz, s3_negx, s3_negy;
  logic [COORD_BITS-1:0] s3_absx, s3_absy;
  logic signed [COORD_BITS-1:0] s3_ax, s3_ay, s3_cx, s3_cy;

  // stage 4: sign normalisation and special cases
  logic signed [SW-1:0] s4_dn, s4_tnn, s4_unn;
  logic                 s4_shared, s4_rz, s4_sz, s4_par, s4_dega, s4_degc, s4_col;
  logic                 s4_negx, s4_negy;
  logic [COORD_BITS-1:0] s4_absx, s4_absy;
  logic signed [COORD_BITS-1:0] s4_ax, s4_ay, s4_cx, s4_cy;

  // stage 5: decision and scaled numerators
  logic [PRW-1:0] s5_prodx, s5_prody;
  logic [MW-1:0]  s5_den;
  segi_side_t     s5_side, side_next;
  logic           is_cross;
  logic signed [SW:0] dws_ss;

  assign dws_ss = (SW+1)'(s3_dws) + (SW+1)'(s3_ss);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[4:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    s1_rx <= DW'(seg.bx) - DW'(seg.ax);
    s1_ry <= DW'(seg.by_coord) - DW'(seg.ay);
    s1_sx <= DW'(seg.dx) - DW'(seg.cx);
    s1_sy <= DW'(seg.dy) - DW'(seg.cy);
    s1_wx <= DW'(seg.cx) - DW'(seg.ax);
    s1_wy <= DW'(seg.cy) - DW'(seg.ay);
    s1_ux <= DW'(seg.dx) - DW'(seg.ax);
    s1_uy <= DW'(seg.dy) - DW'(seg.ay);
    s1_shared <= (seg.ax == seg.cx && seg.ay == seg.cy) ||
                 (seg.ax == seg.dx && seg.ay == seg.dy) ||
                 (seg.bx == seg.cx && seg.by_coord == seg.cy) ||
                 (seg.bx == seg.dx && seg.by_coord == seg.dy);
    s1_ax <= seg.ax;
    s1_ay <= seg.ay;
    s1_cx <= seg.cx;
    s1_cy <= seg.cy;

    s2_ws1 <= s1_wx * s1_sy;
    s2_ws2 <= s1_wy * s1_sx;
    s2_rs1 <= s1_rx * s1_sy;
    s2_rs2 <= s1_ry * s1_sx;
    s2_wr1 <= s1_wx * s1_ry;
    s2_wr2 <= s1_wy * s1_rx;
    s2_wrx <= s1_wx * s1_rx;
    s2_wry <= s1_wy * s1_ry;
    s2_urx <= s1_ux * s1_rx;
    s2_ury <= s1_uy * s1_ry;
    s2_rrx <= s1_rx * s1_rx;
    s2_rry <= s1_ry * s1_ry;
    s2_wsx <= s1_wx * s1_sx;
    s2_wsy <= s1_wy * s1_sy;
    s2_ssx <= s1_sx * s1_sx;
    s2_ssy <= s1_sy * s1_sy;
    s2_shared <= s1_shared;
    s2_rz <= (s1_rx == '0) && (s1_ry == '0);
    s2_sz <= (s1_sx == '0) && (s1_sy == '0);
    s2_negx <= s1_rx[DW-1];
    s2_negy <= s1_ry[DW-1];
    s2_absx <= COORD_BITS'(s1_rx[DW-1] ? -s1_rx : s1_rx);
    s2_absy <= COORD_BITS'(s1_ry[DW-1] ? -s1_ry : s1_ry);
    s2_ax <= s1_ax;
    s2_ay <= s1_ay;
    s2_cx <= s1_cx;
    s2_cy <= s1_cy;

    s3_d   <= s2_rs1 - s2_rs2;
    s3_tn  <= s2_ws1 - s2_ws2;
    s3_un  <= s2_wr1 - s2_wr2;
    s3_t0  <= s2_wrx + s2_wry;
    s3_t1  <= s2_urx + s2_ury;
    s3_rr  <= s2_rrx + s2_rry;
    s3_dws <= s2_wsx + s2_wsy;
    s3_ss  <= s2_ssx + s2_ssy;
    s3_shared <= s2_shared;
    s3_rz <= s2_rz;
    s3_sz <= s2_sz;
    s3_negx <= s2_negx;
    s3_negy <= s2_negy;
    s3_absx <= s2_absx;
    s3_absy <= s2_absy;
    s3_ax <= s2_ax;
    s3_ay <= s2_ay;
    s3_cx <= s2_cx;
    s3_cy <= s2_cy;

    s4_dn  <= s3_d[SW-1] ? -s3_d : s3_d;
    s4_tnn <= s3_d[SW-1] ? -s3_tn : s3_tn;
    s4_unn <= s3_d[SW-1] ? -s3_un : s3_un;
    s4_par <= (s3_d == '0);
    // point A on segment CD, point C on segment AB
    s4_dega <= s3_rz && !s3_sz && (s3_tn == '0) && (s3_dws <= 0) && (dws_ss >= 0);
    s4_degc <= s3_sz && !s3_rz && (s3_un == '0) && (s3_t0 >= 0) && (s3_t0 <= s3_rr);
    s4_col  <= (s3_un == '0) && (s3_t0 >= 0 || s3_t1 >= 0) &&
               (s3_t0 <= s3_rr || s3_t1 <= s3_rr);
    s4_shared <= s3_shared;
    s4_rz <= s3_rz;
    s4_sz <= s3_sz;
    s4_negx <= s3_negx;
    s4_negy <= s3_negy;
    s4_absx <= s3_absx;
    s4_absy <= s3_absy;
    s4_ax <= s3_ax;
    s4_ay <= s3_ay;
    s4_cx <= s3_cx;
    s4_cy <= s3_cy;

    s5_prodx <= PRW'(s4_tnn[MW-1:0]) * PRW'(s4_absx);
    s5_prody <= PRW'(s4_tnn[MW-1:0]) * PRW'(s4_absy);
    s5_den   <= s4_dn[MW-1:0];
    s5_side  <= side_next;
  end

  always_comb begin
    is_cross = !s4_par && (s4_tnn >= 0) && (s4_tnn <= s4_dn) &&
               (s4_unn >= 0) && (s4_unn <= s4_dn);
    side_next       = '0;
    side_next.kind  = KIND_NONE;
    side_next.negx  = s4_negx;
    side_next.negy  = s4_negy;
    side_next.basex = s4_degc ? s4_cx : s4_ax;
    side_next.basey = s4_degc ? s4_cy : s4_ay;
    priority if (s4_shared) begin
      side_next.kind = KIND_SHARED;
    end else if (s4_rz || s4_sz) begin
      if (s4_dega || s4_degc) begin
        side_next.hit  = 1'b1;
        side_next.kind = KIND_POINT;
        side_next.pt   = 1'b1;
      end
    end else if (s4_par) begin
      if (s4_col) begin
        side_next.hit  = 1'b1;
        side_next.kind = KIND_OVERLAP;
      end
    end else if (is_cross) begin
      side_next.hit  = 1'b1;
      side_next.kind = KIND_POINT;
      side_next.pt   = 1'b1;
      side_next.off  = 1'b1;
    end
  end

  assign out_valid = vld[5];
  assign side      = s5_side;
  assign n_x       = NW'(s5_prodx) << FRAC_BITS;
  assign n_y       = NW'(s5_prody) << FRAC_BITS;
  assign den       = s5_den;

endmodule

// ----- rtl/core/segi_div.sv -----
module segi_div (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic [segi_pkg::NW-1:0] n_x,
  input  logic [segi_pkg::NW-1:0] n_y,
  input  logic [segi_pkg::MW-1:0] den,
  input  segi_pkg::segi_side_t    side_in,
  output logic                    out_valid,
  output logic [segi_pkg::QW-1:0] q_x,
  output logic [segi_pkg::QW-1:0] q_y,
  output segi_pkg::segi_side_t    side_out
);
  import segi_pkg::*;

  // One quotient bit per stage. The low word shifts dividend bits out at the
  // top and quotient bits in at the bottom.
  function automatic logic [MW+QW-1:0] div_step(input logic [MW-1:0] rem,
                                                input logic [QW-1:0] low,
                                                input logic [MW-1:0] dv);
    logic [MW:0]   t;
    logic          ge;
    logic [MW-1:0] rn;
    t  = {rem, low[QW-1]};
    ge = (t >= {1'b0, dv});
    rn = ge ? MW'(t - {1'b0, dv}) : t[MW-1:0];
    return {rn, low[QW-2:0], ge};
  endfunction

  logic [QW-1:0]     vld;
  logic [MW-1:0]     rem_x [QW];
  logic [QW-1:0]     low_x [QW];
  logic [MW-1:0]     rem_y [QW];
  logic [QW-1:0]     low_y [QW];
  logic [MW-1:0]     dv    [QW];
  segi_side_t        sd    [QW];
  logic [MW+QW-1:0]  nx_x  [QW];
  logic [MW+QW-1:0]  nx_y  [QW];

  always_comb begin
    nx_x[0] = div_step(n_x[NW-1:QW], n_x[QW-1:0], den);
    nx_y[0] = div_step(n_y[NW-1:QW], n_y[QW-1:0], den);
    for (int k = 1; k < QW; k++) begin
      nx_x[k] = div_step(rem_x[k-1], low_x[k-1], dv[k-1]);
      nx_y[k] = div_step(rem_y[k-1], low_y[k-1], dv[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[QW-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    dv[0] <= den;
    sd[0] <= side_in;
    for (int k = 1; k < QW; k++) begin
      dv[k] <= dv[k-1];
      sd[k] <= sd[k-1];
    end
    for (int k = 0; k < QW; k++) begin
      {rem_x[k], low_x[k]} <= nx_x[k];
      {rem_y[k], low_y[k]} <= nx_y[k];
    end
  end

  assign out_valid = vld[QW-1];
  assign q_x       = low_x[QW-1];
  assign q_y       = low_y[QW-1];
  assign side_out  = sd[QW-1];

endmodule

// ----- rtl/core/segment_intersection_test.sv -----
// Pipeline: 5 geometry stages, 32 divider stages and 1 output stage; the
// divider resolves one quotient bit per stage.
// Throughput: one item per cycle; busy is always low and results cannot
// be held off, so items leave in the order they entered.
// Reset (rst, synchronous) empties the pipeline: items in flight are
// dropped and done stays low until new items arrive.
module segment_intersection_test (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  segi_pkg::seg_in_t  seg,
  output logic               done,
  output segi_pkg::seg_out_t result
);
  import segi_pkg::*;

  localparam int LAT = 5 + QW + 1;

  logic                 f_valid;
  segi_side_t           f_side;
  logic [NW-1:0]        f_nx, f_ny;
  logic [MW-1:0]        f_den;

  logic                 d_valid;
  logic [QW-1:0]        d_qx, d_qy;
  segi_side_t           d_side;

  // Never stall: every cycle may take a fresh item.
  assign busy = 1'b0;

  segi_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .seg       (seg),
    .out_valid (f_valid),
    .side      (f_side),
    .n_x       (f_nx),
    .n_y       (f_ny),
    .den       (f_den)
  );

  segi_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .n_x       (f_nx),
    .n_y       (f_ny),
    .den       (f_den),
    .side_in   (f_side),
    .out_valid (d_valid),
    .q_x       (d_qx),
    .q_y       (d_qy),
    .side_out  (d_side)
  );

  // Final stage: scale the base point, add the signed offset, clamp to the
  // 32-bit output range, and drop the point when there is no single one.
  localparam logic signed [EW-1:0] SMAX = EW'(32'sh7FFF_FFFF);
  localparam logic signed [EW-1:0] SMIN = ~SMAX;

  logic signed [EW-1:0] basex, basey, offx, offy, sumx, sumy;
  logic signed [EW-1:0] qx_e, qy_e, satx, saty;
  seg_out_t             result_next;

  always_comb begin
    basex = EW'(d_side.basex) <<< FRAC_BITS;
    basey = EW'(d_side.basey) <<< FRAC_BITS;
    qx_e  = EW'(d_qx);
    qy_e  = EW'(d_qy);
    offx  = d_side.off ? (d_side.negx ? -qx_e : qx_e) : '0;
    offy  = d_side.off ? (d_side.negy ? -qy_e : qy_e) : '0;
    sumx  = basex + offx;
    sumy  = basey + offy;
    satx  = (sumx > SMAX) ? SMAX : ((sumx < SMIN) ? SMIN : sumx);
    saty  = (sumy > SMAX) ? SMAX : ((sumy < SMIN) ? SMIN : sumy);
    result_next.hit  = d_side.hit;
    result_next.kind = d_side.kind;
    result_next.px   = d_side.pt ? satx[OUT_W-1:0] : '0;
    result_next.py   = d_side.pt ? saty[OUT_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

  // A result only ever leaves for an item that was taken earlier with start.
  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result without a matching item");

  // No hit means no point.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !result.hit) |-> (result.px == '0 && result.py == '0))
    else $error("point reported without a hit");

  // Overlap carries no point, and a hit is never of kind none or shared.
  a_hit_kind: assert property (@(posedge clk) disable iff (rst)
    (done && result.hit) |->
      (result.kind == KIND_POINT || result.kind == KIND_OVERLAP))
    else $error("hit with a wrong kind");

  a_overlap_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.kind == KIND_OVERLAP) |-> (result.px == '0 && result.py == '0))
    else $error("overlap with a point");

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import segi_pkg::*;

  localparam int LATENCY = 38;
  localparam int CYCLE_LIMIT = 200000;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  logic     busy;
  seg_in_t  seg = '0;
  logic     done;
  seg_out_t result;

  segment_intersection_test i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .seg(seg), .done(done), .result(result)
  );

  always #5 clk = ~clk;

  // Expected crossings, oldest first.
  seg_out_t crossing_q[$];
  int mismatches = 0;
  int cycles = 0;
  bit idle_mode = 1'b0;

  // Exact integer geometry; 34-bit products and 35-bit sums of 17-bit differences
  // cannot overflow a 64-bit longint.
  function automatic longint cross2(longint ux, longint uy, longint vx, longint vy);
    return ux * vy - uy * vx;
  endfunction

  function automatic longint dot2(longint ux, longint uy, longint vx, longint vy);
    return ux * vx + uy * vy;
  endfunction

  function automatic bit lies_on(longint qx, longint qy, longint s0x, longint s0y,
                                 longint s1x, longint s1y);
    longint ex, ey, wx, wy, t;
    ex = s1x - s0x; ey = s1y - s0y; wx = qx - s0x; wy = qy - s0y;
    if (cross2(wx, wy, ex, ey) != 0) return 1'b0;
    t = dot2(wx, wy, ex, ey);
    return t >= 0 && t <= dot2(ex, ey, ex, ey);
  endfunction

  function automatic logic signed [OUT_W-1:0] clamp32(logic signed [127:0] v);
    if (v > 128'sd2147483647) return 32'sh7fffffff;
    if (v < -128'sd2147483648) return 32'sh80000000;
    return v[OUT_W-1:0];
  endfunction

  // Offset along one axis, truncated toward zero.
  function automatic logic signed [127:0] axis_offset(longint comp, longint tn, longint d);
    logic [127:0] num, q;
    logic [127:0] mag;
    mag = 128'(comp < 0 ? -comp : comp);
    num = mag * tn * (128'd1 << FRAC_BITS);
    q = num / d;
    return comp < 0 ? -$signed(q) : $signed(q);
  endfunction

  function automatic seg_out_t predict_crossing(seg_in_t s);
    seg_out_t o;
    longint ax, ay, bx, by, cx, cy, dx, dy, rx, ry, sx, sy, wx, wy;
    longint d, tn, un, t0, t1, lo, hi;
    logic signed [127:0] one;
    bit rz, sz;
    ax = longint'(s.ax); ay = longint'(s.ay);
    bx = longint'(s.bx); by = longint'(s.by_coord);
    cx = longint'(s.cx); cy = longint'(s.cy);
    dx = longint'(s.dx); dy = longint'(s.dy);
    rx = bx - ax; ry = by - ay; sx = dx - cx; sy = dy - cy;
    wx = cx - ax; wy = cy - ay;
    rz = rx == 0 && ry == 0; sz = sx == 0 && sy == 0;
    one = 128'sd1 <<< FRAC_BITS;
    o = '0;
    o.kind = KIND_NONE;
    if ((ax == cx && ay == cy) || (ax == dx && ay == dy) ||
        (bx == cx && by == cy) || (bx == dx && by == dy)) begin
      o.kind = KIND_SHARED;
    end else if (rz || sz) begin
      if (rz && !sz && lies_on(ax, ay, cx, cy, dx, dy)) begin
        o.hit = 1'b1; o.kind = KIND_POINT;
        o.px = clamp32(ax * one); o.py = clamp32(ay * one);
      end else if (sz && !rz && lies_on(cx, cy, ax, ay, bx, by)) begin
        o.hit = 1'b1; o.kind = KIND_POINT;
        o.px = clamp32(cx * one); o.py = clamp32(cy * one);
      end
    end else begin
      d = cross2(rx, ry, sx, sy);
      tn = cross2(wx, wy, sx, sy);
      un = cross2(wx, wy, rx, ry);
      if (d == 0) begin
        if (un == 0) begin
          t0 = dot2(wx, wy, rx, ry);
          t1 = dot2(dx - ax, dy - ay, rx, ry);
          lo = t0 <= t1 ? t0 : t1;
          hi = t0 <= t1 ? t1 : t0;
          if (hi >= 0 && lo <= dot2(rx, ry, rx, ry)) begin
            o.hit = 1'b1; o.kind = KIND_OVERLAP;
          end
        end
      end else begin
        if (d < 0) begin
          d = -d; tn = -tn; un = -un;
        end
        if (tn >= 0 && tn <= d && un >= 0 && un <= d) begin
          o.hit = 1'b1; o.kind = KIND_POINT;
          o.px = clamp32(ax * one + axis_offset(rx, tn, d));
          o.py = clamp32(ay * one + axis_offset(ry, tn, d));
        end
      end
    end
    return o;
  endfunction

  // Gap before an item: often none, mostly short, now and then long.
  function automatic int gap_len();
    int r;
    if (!idle_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Send one item: hold start across back-to-back items, drop it in gaps.
  task automatic send_item(seg_in_t s);
    int g;
    g = gap_len();
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(negedge clk);
    end
    seg <= s;
    start <= 1'b1;
    crossing_q.push_back(predict_crossing(s));
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic release_line();
    start <= 1'b0;
  endtask

  // Check every result against the oldest expectation.
  always @(posedge clk) begin
    seg_out_t want;
    if (!rst && done) begin
      if (crossing_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", result);
      end else begin
        want = crossing_q.pop_front();
        if (result.hit !== want.hit || result.kind !== want.kind ||
            result.px !== want.px || result.py !== want.py) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: expected hit=%0d kind=%0d px=%0d py=%0d, ",
                      "got hit=%0d kind=%0d px=%0d py=%0d"},
                     want.hit, want.kind, want.px, want.py,
                     result.hit, result.kind, result.px, result.py);
        end
      end
    end
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic seg_in_t make_seg(int ax, int ay, int bx, int by,
                                       int cx, int cy, int dx, int dy);
    seg_in_t s;
    s.ax = COORD_BITS'(ax); s.ay = COORD_BITS'(ay);
    s.bx = COORD_BITS'(bx); s.by_coord = COORD_BITS'(by);
    s.cx = COORD_BITS'(cx); s.cy = COORD_BITS'(cy);
    s.dx = COORD_BITS'(dx); s.dy = COORD_BITS'(dy);
    return s;
  endfunction

  function automatic int rnd_coord(int span);
    if (span == 0) return int'($signed(16'($urandom)));
    return $signed($urandom_range(0, 2 * span)) - span;
  endfunction

  // Directed: each geometric case and the coordinate extremes.
  task automatic test_directed();
    idle_mode = 1'b0;
    send_item(make_seg(0, 0, 10, 10, 0, 10, 10, 0));          // plain crossing
    send_item(make_seg(0, 0, 3, 1, 0, 1, 3, 0));              // fractional point
    send_item(make_seg(0, 0, 10, 0, 5, 5, 5, 0));             // touch at C..D end
    send_item(make_seg(0, 0, 10, 0, 10, 5, 10, -5));          // touch at B
    send_item(make_seg(0, 0, 10, 0, 0, 0, 5, 5));             // shared endpoint
    send_item(make_seg(1, 1, 4, 4, 4, 4, 9, 0));              // shared B=C
    send_item(make_seg(0, 0, 10, 0, 0, 1, 10, 1));            // parallel
    send_item(make_seg(0, 0, 10, 0, 5, 0, 15, 0));            // collinear overlap
    send_item(make_seg(0, 0, 10, 0, 12, 0, 15, 0));           // collinear disjoint
    send_item(make_seg(0, 0, 0, 10, 0, 3, 0, 20));            // vertical overlap
    send_item(make_seg(5, 0, 5, 0, 0, 0, 10, 0));             // point on segment
    send_item(make_seg(5, 1, 5, 1, 0, 0, 10, 0));             // point off segment
    send_item(make_seg(0, 0, 10, 10, 3, 3, 3, 3));            // point CD on AB
    send_item(make_seg(1, 1, 1, 1, 2, 2, 2, 2));              // two points
    send_item(make_seg(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    send_item(make_seg(32767, 32767, -32768, 32767, 0, -32768, 0, 32767));
    send_item(make_seg(-32768, 0, 32767, 0, -32767, -32768, -32767, 32767));
    send_item(make_seg(32767, -32768, 32767, 32767, -32768, 32767, 32767, 0));
    send_item(make_seg(-1, -1, -1, -1, -32768, -32768, 32767, 32767));
    release_line();
  endtask

  // Wait with start low until every expectation is met.
  task automatic test_drain_pause();
    while (crossing_q.size() != 0) @(negedge clk);
    repeat ($urandom_range(0, 5)) @(negedge clk);
  endtask

  // Random pairs: mostly small boxes so crossings are common.
  task automatic test_random(int n, bit gaps);
    seg_in_t s;
    int span, r;
    idle_mode = gaps;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 9);
      span = r < 5 ? 20 : (r < 8 ? 2000 : 0);
      s = make_seg(rnd_coord(span), rnd_coord(span), rnd_coord(span), rnd_coord(span),
                   rnd_coord(span), rnd_coord(span), rnd_coord(span), rnd_coord(span));
      r = $urandom_range(0, 9);
      if (r == 0) begin                 // shared endpoint
        s.cx = s.bx; s.cy = s.by_coord;
      end else if (r == 1) begin        // collinear along AB
        s.cx = COORD_BITS'(s.ax + 2 * (s.bx - s.ax));
        s.cy = COORD_BITS'(s.ay + 2 * (s.by_coord - s.ay));
        s.dx = COORD_BITS'(s.ax - (s.bx - s.ax));
        s.dy = COORD_BITS'(s.ay - (s.by_coord - s.ay));
      end else if (r == 2) begin        // degenerate AB
        s.bx = s.ax; s.by_coord = s.ay;
      end
      send_item(s);
    end
    release_line();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_drain_pause();
    test_random(250, 1'b1);
    test_drain_pause();
    test_random(250, 1'b0);
    while (crossing_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
    if (mismatches == 0 && crossing_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
